@@ rtl/core/mer_pkg.sv @@
// Shared types and constants for the midpoint ellipse rasterizer.
// Used by mer_ctrl, mer_dpath and the top level; depends on nothing.
package mer_pkg;

    localparam int COORD_BITS_DEF  = 12;
    localparam int RADIUS_BITS_DEF = 11;
    localparam int PIXEL_BITS      = 14;
    localparam int COLOR_BITS      = 24;

    // action field codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // quadrant codes, emitted in this order
    localparam logic [1:0] QUAD_PP = 2'd0;   // +x, +y
    localparam logic [1:0] QUAD_PN = 2'd1;   // +x, -y
    localparam logic [1:0] QUAD_NN = 2'd2;   // -x, -y
    localparam logic [1:0] QUAD_NP = 2'd3;   // -x, +y

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ_A,
        OP_SQ_B,
        OP_A2B,
        OP_INIT_D,
        OP_MUL_BX,
        OP_MUL_AY,
        OP_SQ_T,
        OP_MUL_BT,
        OP_SQ_Y,
        OP_MUL_AYY,
        OP_ADD_AYY,
        OP_SUB_AB,
        OP_R1_STEP,
        OP_R1_ADD,
        OP_R1_SUB,
        OP_R2_STEP,
        OP_R2_ADD,
        OP_R2_FIX,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [1:0] quad;
        logic       last;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;   // output register can take a beat this cycle
        logic ge;         // b^2*x >= a^2*y from the last product pair
        logic y_zero;     // current point lies on the x axis
        logic reg2;       // in region 2
    } t_dp_stat;

endpackage

@@ rtl/core/mer_ctrl.sv @@
// Sequencer for the midpoint ellipse rasterizer.
// Steps mer_dpath through load, region switch, advance and emit; uses mer_pkg.
module mer_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_action,
    output logic                o_ready,
    input  mer_pkg::t_dp_stat   i_stat,
    output mer_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_A,
        ST_SQ_B,
        ST_A2B,
        ST_INIT_D,
        ST_S_BX,
        ST_S_AY,
        ST_S_CHECK,
        ST_SQ_T,
        ST_MUL_BT,
        ST_SQ_Y,
        ST_MUL_AYY,
        ST_ADD_AYY,
        ST_SUB_AB,
        ST_R1_STEP,
        ST_R1_BX,
        ST_R1_ADD,
        ST_R1_SUB,
        ST_R2_STEP,
        ST_R2_AY,
        ST_R2_ADD,
        ST_R2_FIX,
        ST_EMIT0,
        ST_EMIT1,
        ST_EMIT2,
        ST_EMIT3
    } t_state;

    t_state r_state, n_state;
    logic   r_drawing, n_drawing;

    assign o_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state    = r_state;
        n_drawing  = r_drawing;
        o_cmd.op   = mer_pkg::OP_NONE;
        o_cmd.quad = mer_pkg::QUAD_PP;
        o_cmd.last = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_action == mer_pkg::ACT_START) begin
                        o_cmd.op  = mer_pkg::OP_LOAD;
                        n_drawing = 1'b1;
                        n_state   = ST_SQ_A;
                    end else if (r_drawing) begin
                        n_state = ST_EMIT0;
                    end
                end
            end
            ST_SQ_A: begin
                o_cmd.op = mer_pkg::OP_SQ_A;
                n_state  = ST_SQ_B;
            end
            ST_SQ_B: begin
                o_cmd.op = mer_pkg::OP_SQ_B;
                n_state  = ST_A2B;
            end
            ST_A2B: begin
                o_cmd.op = mer_pkg::OP_A2B;
                n_state  = ST_INIT_D;
            end
            ST_INIT_D: begin
                o_cmd.op = mer_pkg::OP_INIT_D;
                n_state  = ST_S_BX;
            end
            ST_S_BX: begin
                o_cmd.op = mer_pkg::OP_MUL_BX;
                n_state  = ST_S_AY;
            end
            ST_S_AY: begin
                o_cmd.op = mer_pkg::OP_MUL_AY;
                n_state  = ST_S_CHECK;
            end
            ST_S_CHECK: begin
                n_state = i_stat.ge ? ST_SQ_T : ST_IDLE;
            end
            ST_SQ_T: begin
                o_cmd.op = mer_pkg::OP_SQ_T;
                n_state  = ST_MUL_BT;
            end
            ST_MUL_BT: begin
                o_cmd.op = mer_pkg::OP_MUL_BT;
                n_state  = ST_SQ_Y;
            end
            ST_SQ_Y: begin
                o_cmd.op = mer_pkg::OP_SQ_Y;
                n_state  = ST_MUL_AYY;
            end
            ST_MUL_AYY: begin
                o_cmd.op = mer_pkg::OP_MUL_AYY;
                n_state  = ST_ADD_AYY;
            end
            ST_ADD_AYY: begin
                o_cmd.op = mer_pkg::OP_ADD_AYY;
                n_state  = ST_SUB_AB;
            end
            ST_SUB_AB: begin
                o_cmd.op = mer_pkg::OP_SUB_AB;
                n_state  = ST_IDLE;
            end
            ST_R1_STEP: begin
                o_cmd.op = mer_pkg::OP_R1_STEP;
                n_state  = ST_R1_BX;
            end
            ST_R1_BX: begin
                o_cmd.op = mer_pkg::OP_MUL_BX;
                n_state  = ST_R1_ADD;
            end
            ST_R1_ADD: begin
                o_cmd.op = mer_pkg::OP_R1_ADD;
                n_state  = ST_R1_SUB;
            end
            ST_R1_SUB: begin
                // products now hold b^2*x and a^2*y of the new point
                o_cmd.op = mer_pkg::OP_R1_SUB;
                n_state  = i_stat.ge ? ST_SQ_T : ST_IDLE;
            end
            ST_R2_STEP: begin
                o_cmd.op = mer_pkg::OP_R2_STEP;
                n_state  = ST_R2_AY;
            end
            ST_R2_AY: begin
                o_cmd.op = mer_pkg::OP_MUL_AY;
                n_state  = ST_R2_ADD;
            end
            ST_R2_ADD: begin
                o_cmd.op = mer_pkg::OP_R2_ADD;
                n_state  = ST_R2_FIX;
            end
            ST_R2_FIX: begin
                o_cmd.op = mer_pkg::OP_R2_FIX;
                n_state  = ST_IDLE;
            end
            ST_EMIT0: begin
                if (i_stat.out_free) begin
                    o_cmd.op   = mer_pkg::OP_EMIT;
                    o_cmd.quad = mer_pkg::QUAD_PP;
                    n_state    = ST_EMIT1;
                end
            end
            ST_EMIT1: begin
                if (i_stat.out_free) begin
                    o_cmd.op   = mer_pkg::OP_EMIT;
                    o_cmd.quad = mer_pkg::QUAD_PN;
                    n_state    = ST_EMIT2;
                end
            end
            ST_EMIT2: begin
                if (i_stat.out_free) begin
                    o_cmd.op   = mer_pkg::OP_EMIT;
                    o_cmd.quad = mer_pkg::QUAD_NN;
                    n_state    = ST_EMIT3;
                end
            end
            ST_EMIT3: begin
                if (i_stat.out_free) begin
                    o_cmd.op   = mer_pkg::OP_EMIT;
                    o_cmd.quad = mer_pkg::QUAD_NP;
                    o_cmd.last = 1'b1;
                    if (i_stat.y_zero) begin
                        // final point: drop back to idle
                        n_drawing = 1'b0;
                        n_state   = ST_IDLE;
                    end else begin
                        n_state = i_stat.reg2 ? ST_R2_STEP : ST_R1_STEP;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_drawing <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_drawing <= n_drawing;
        end
    end

endmodule

@@ rtl/core/mer_dpath.sv @@
// Datapath of the midpoint ellipse rasterizer: held shape, offsets, decision,
// one shared multiplier and the output register. Driven by mer_ctrl; uses mer_pkg.
module mer_dpath #(
    parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mer_pkg::t_dp_cmd                     i_cmd,
    output mer_pkg::t_dp_stat                    o_stat,
    input  logic [COORD_BITS-1:0]                i_center_x,
    input  logic [COORD_BITS-1:0]                i_center_y,
    input  logic [RADIUS_BITS-1:0]               i_radius_a,
    input  logic [RADIUS_BITS-1:0]               i_radius_b,
    input  logic [mer_pkg::COLOR_BITS-1:0]       i_color_in,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [mer_pkg::PIXEL_BITS-1:0] o_pixel_x,
    output logic signed [mer_pkg::PIXEL_BITS-1:0] o_pixel_y,
    output logic [mer_pkg::COLOR_BITS-1:0]       o_pixel_color,
    output logic [1:0]                           o_quadrant,
    output logic                                 o_last_of_step,
    output logic                                 o_final_point
);

    localparam int XW = RADIUS_BITS + 1;       // x may pass the radius by one
    localparam int SW = 2 * RADIUS_BITS;       // squared radius
    localparam int MW = 2 * RADIUS_BITS + 4;   // multiplier operand
    localparam int DW = 4 * RADIUS_BITS + 6;   // decision and product
    localparam int PB = mer_pkg::PIXEL_BITS;

    logic [COORD_BITS-1:0]          r_cx, r_cy;
    logic [mer_pkg::COLOR_BITS-1:0] r_color;
    logic [RADIUS_BITS-1:0]         r_rad_a;
    logic [XW-1:0]                  r_off_x;
    logic [RADIUS_BITS-1:0]         r_off_y;
    logic [SW-1:0]                  r_sqa, r_sqb;
    logic [DW-1:0]                  r_dec, r_prod, r_tmp;
    logic                           r_reg2, r_diag;

    logic [MW-1:0]          w_mul_l, w_mul_r;
    logic [2*MW-1:0]        w_mul;
    logic                   w_load_prod;
    logic [RADIUS_BITS+1:0] w_t;
    logic [RADIUS_BITS-1:0] w_ym1;
    logic                   w_neg, w_pos;
    logic [PB-1:0]          w_cx, w_cy, w_ox, w_oy;

    assign w_t   = {r_off_x, 1'b1};
    // (y-1)^2 with y = 0 squares to one
    assign w_ym1 = (r_off_y == '0) ? RADIUS_BITS'(1) : (r_off_y - RADIUS_BITS'(1));
    assign w_neg = r_dec[DW-1];
    assign w_pos = !w_neg && (r_dec != '0);

    always_comb begin
        w_mul_l     = '0;
        w_mul_r     = '0;
        w_load_prod = 1'b1;
        case (i_cmd.op)
            mer_pkg::OP_SQ_A: begin
                w_mul_l = MW'(r_rad_a);
                w_mul_r = MW'(r_rad_a);
            end
            mer_pkg::OP_SQ_B: begin
                w_mul_l = MW'(r_off_y);
                w_mul_r = MW'(r_off_y);
            end
            mer_pkg::OP_A2B: begin
                w_mul_l = MW'(r_sqa);
                w_mul_r = MW'(r_off_y);
            end
            mer_pkg::OP_MUL_BX, mer_pkg::OP_R2_ADD: begin
                w_mul_l = MW'(r_sqb);
                w_mul_r = MW'(r_off_x);
            end
            mer_pkg::OP_MUL_AY, mer_pkg::OP_R1_ADD: begin
                w_mul_l = MW'(r_sqa);
                w_mul_r = MW'(r_off_y);
            end
            mer_pkg::OP_SQ_T: begin
                w_mul_l = MW'(w_t);
                w_mul_r = MW'(w_t);
            end
            mer_pkg::OP_MUL_BT: begin
                w_mul_l = MW'(r_sqb);
                w_mul_r = r_prod[MW-1:0];
            end
            mer_pkg::OP_SQ_Y: begin
                w_mul_l = MW'(w_ym1);
                w_mul_r = MW'(w_ym1);
            end
            mer_pkg::OP_MUL_AYY: begin
                w_mul_l = MW'(r_sqa);
                w_mul_r = r_prod[MW-1:0];
            end
            mer_pkg::OP_ADD_AYY: begin
                w_mul_l = MW'(r_sqa);
                w_mul_r = MW'(r_sqb);
            end
            default: begin
                w_load_prod = 1'b0;
            end
        endcase
    end

    assign w_mul = w_mul_l * w_mul_r;

    // products, held shape, offsets, decision
    always_ff @(posedge i_clk) begin
        if (w_load_prod) begin
            r_prod <= w_mul[DW-1:0];
        end
        case (i_cmd.op)
            mer_pkg::OP_LOAD: begin
                r_cx    <= i_center_x;
                r_cy    <= i_center_y;
                r_color <= i_color_in;
                r_rad_a <= i_radius_a;
                r_off_y <= i_radius_b;
                r_off_x <= '0;
            end
            mer_pkg::OP_SQ_B: begin
                r_sqa <= r_prod[SW-1:0];
            end
            mer_pkg::OP_A2B: begin
                r_sqb <= r_prod[SW-1:0];
            end
            mer_pkg::OP_INIT_D: begin
                r_dec <= (DW'(r_sqb) << 2) - (r_prod << 2) + DW'(r_sqa);
            end
            mer_pkg::OP_MUL_AY: begin
                r_tmp <= r_prod;
            end
            mer_pkg::OP_SQ_Y: begin
                r_dec <= r_prod;
            end
            mer_pkg::OP_ADD_AYY: begin
                r_dec <= r_dec + (r_prod << 2);
            end
            mer_pkg::OP_SUB_AB: begin
                r_dec <= r_dec - (r_prod << 2);
            end
            mer_pkg::OP_R1_STEP: begin
                r_off_x <= r_off_x + XW'(1);
                r_diag  <= !w_neg;
                if (!w_neg) begin
                    r_off_y <= r_off_y - RADIUS_BITS'(1);
                end
            end
            mer_pkg::OP_R1_ADD: begin
                r_tmp <= r_prod;
                r_dec <= r_dec + (r_prod << 3) + (DW'(r_sqb) << 2);
            end
            mer_pkg::OP_R1_SUB: begin
                if (r_diag) begin
                    r_dec <= r_dec - (r_prod << 3);
                end
            end
            mer_pkg::OP_R2_STEP: begin
                r_off_y <= r_off_y - RADIUS_BITS'(1);
                r_diag  <= !w_pos;
                if (!w_pos) begin
                    r_off_x <= r_off_x + XW'(1);
                end
            end
            mer_pkg::OP_R2_ADD: begin
                r_dec <= r_dec + (DW'(r_sqa) << 2) - (r_prod << 3);
            end
            mer_pkg::OP_R2_FIX: begin
                if (r_diag) begin
                    r_dec <= r_dec + (r_prod << 3);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg2 <= 1'b0;
        end else if (i_cmd.op == mer_pkg::OP_LOAD) begin
            r_reg2 <= 1'b0;
        end else if (i_cmd.op == mer_pkg::OP_SUB_AB) begin
            r_reg2 <= 1'b1;
        end
    end

    // output register: hold the beat until taken
    assign w_cx = PB'(r_cx);
    assign w_cy = PB'(r_cy);
    assign w_ox = PB'(r_off_x);
    assign w_oy = PB'(r_off_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.op == mer_pkg::OP_EMIT) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == mer_pkg::OP_EMIT) begin
            o_pixel_x      <= ((i_cmd.quad == mer_pkg::QUAD_PP) ||
                               (i_cmd.quad == mer_pkg::QUAD_PN)) ? (w_cx + w_ox)
                                                                 : (w_cx - w_ox);
            o_pixel_y      <= ((i_cmd.quad == mer_pkg::QUAD_PP) ||
                               (i_cmd.quad == mer_pkg::QUAD_NP)) ? (w_cy + w_oy)
                                                                 : (w_cy - w_oy);
            o_pixel_color  <= r_color;
            o_quadrant     <= i_cmd.quad;
            o_last_of_step <= i_cmd.last;
            o_final_point  <= (r_off_y == '0);
        end
    end

    assign o_stat.out_free = !o_valid || i_ready;
    assign o_stat.ge       = (r_tmp >= r_prod);
    assign o_stat.y_zero   = (r_off_y == '0);
    assign o_stat.reg2     = r_reg2;

endmodule

@@ rtl/core/midpoint_ellipse_raster.sv @@
// Midpoint ellipse rasterizer: a start beat loads center, radii and color; each
// step beat emits four symmetric pixels, one per cycle while the pixel sink does not
// stall, then updates the decision, except after the final point. A start may
// already switch to region 2. The products come from the shared multiplier in
// mer_dpath. Synchronous active-low reset returns to idle.
module midpoint_ellipse_raster #(
    parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_action,
    input  logic [COORD_BITS-1:0]                 i_center_x,
    input  logic [COORD_BITS-1:0]                 i_center_y,
    input  logic [RADIUS_BITS-1:0]                i_radius_a,
    input  logic [RADIUS_BITS-1:0]                i_radius_b,
    input  logic [mer_pkg::COLOR_BITS-1:0]        i_color_in,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [mer_pkg::PIXEL_BITS-1:0] o_pixel_x,
    output logic signed [mer_pkg::PIXEL_BITS-1:0] o_pixel_y,
    output logic [mer_pkg::COLOR_BITS-1:0]        o_pixel_color,
    output logic [1:0]                            o_quadrant,
    output logic                                  o_last_of_step,
    output logic                                  o_final_point
);

    mer_pkg::t_dp_cmd  w_cmd;
    mer_pkg::t_dp_stat w_stat;

    mer_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .o_ready  (o_ready),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd)
    );

    mer_dpath #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_radius_a     (i_radius_a),
        .i_radius_b     (i_radius_b),
        .i_color_in     (i_color_in),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_color  (o_pixel_color),
        .o_quadrant     (o_quadrant),
        .o_last_of_step (o_last_of_step),
        .o_final_point  (o_final_point)
    );

endmodule

@@ rtl/core/mer_checker.sv @@
// Port-level checks for midpoint_ellipse_raster, attached by bind.
// Watches the output beats against the input handshake; uses mer_pkg.
module mer_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  o_ready,
    input logic                                  o_valid,
    input logic                                  i_ready,
    input logic signed [mer_pkg::PIXEL_BITS-1:0] o_pixel_x,
    input logic signed [mer_pkg::PIXEL_BITS-1:0] o_pixel_y,
    input logic [1:0]                            o_quadrant,
    input logic                                  o_last_of_step,
    input logic                                  o_final_point
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pixel_x) && $stable(o_pixel_y)
            && $stable(o_quadrant))
        else $error("output beat changed while stalled");

    a_last_quad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_of_step == (o_quadrant == mer_pkg::QUAD_NP)))
        else $error("last_of_step does not match the fourth quadrant");

    a_busy_mid_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_step |-> !o_ready)
        else $error("input taken before a step finished emitting");

    a_quad_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_of_step |=>
            !o_valid || (o_quadrant == $past(o_quadrant) + 2'd1))
        else $error("quadrants out of order within a step");

    a_final_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_of_step |=> !o_valid || $stable(o_final_point))
        else $error("final_point changed within a step");

endmodule

bind midpoint_ellipse_raster mer_checker u_mer_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_pixel_x      (o_pixel_x),
    .o_pixel_y      (o_pixel_y),
    .o_quadrant     (o_quadrant),
    .o_last_of_step (o_last_of_step),
    .o_final_point  (o_final_point)
);

@@ tb/testbench.sv @@
// Self-checking bench for midpoint_ellipse_raster: mer_pkg and the RTL are all it needs.
// A scoreboard class tracks the rasterizer state and queues the four pixels of each step.
// Tasks drive start and step beats in random bursts against a stalling pixel sink.
module testbench;

    localparam int CW = mer_pkg::COORD_BITS_DEF;
    localparam int RW = mer_pkg::RADIUS_BITS_DEF;
    localparam int PW = mer_pkg::PIXEL_BITS;
    localparam int KW = mer_pkg::COLOR_BITS;
    // Slowest gap between two beats is a region switch plus sink stalls
    // and a sender gap; this is many times that.
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 70;

    typedef struct packed {
        logic [PW-1:0] px;
        logic [PW-1:0] py;
        logic [KW-1:0] color;
        logic [1:0]    quad;
        logic          last;
        logic          fin;
    } t_pixel_beat;

    class ellipse_scoreboard;
        t_pixel_beat pending_pixels[$];
        int          errors;
        int          pixels_checked;
        int          starts;
        int          restarts;
        int          steps;
        int          ellipses_done;

        // rasterizer state
        longint          off_x;
        longint          off_y;
        longint          dec;
        bit              region_two;
        bit              drawing;
        logic [CW-1:0]   ctr_x;
        logic [CW-1:0]   ctr_y;
        longint          a_sq;
        longint          b_sq;
        logic [KW-1:0]   ink;

        function new();
            pending_pixels.delete();
            errors = 0;
            pixels_checked = 0;
            starts = 0;
            restarts = 0;
            steps = 0;
            ellipses_done = 0;
            off_x = 0;
            off_y = 0;
            dec = 0;
            region_two = 0;
            drawing = 0;
            ctr_x = '0;
            ctr_y = '0;
            a_sq = 0;
            b_sq = 0;
            ink = '0;
        endfunction

        task report(input string msg);
            errors++;
            $display("mismatch at %0t: %s", $time, msg);
        endtask

        // Enter region 2 once the slope passes -1; reload the decision there.
        function void test_switch();
            longint t;
            longint ym1;
            if (b_sq * off_x >= a_sq * off_y) begin
                t = 2 * off_x + 1;
                ym1 = off_y - 1;
                region_two = 1;
                dec = b_sq * t * t + 4 * a_sq * ym1 * ym1 - 4 * a_sq * b_sq;
            end
        endfunction

        function void next_point();
            if (!region_two) begin
                off_x = off_x + 1;
                if (dec < 0) begin
                    dec += 8 * b_sq * off_x + 4 * b_sq;
                end else begin
                    off_y = off_y - 1;
                    dec += 8 * b_sq * off_x - 8 * a_sq * off_y + 4 * b_sq;
                end
                test_switch();
            end else begin
                off_y = off_y - 1;
                if (dec > 0) begin
                    dec += 4 * a_sq - 8 * a_sq * off_y;
                end else begin
                    off_x = off_x + 1;
                    dec += 8 * b_sq * off_x - 8 * a_sq * off_y + 4 * a_sq;
                end
            end
        endfunction

        // Track one accepted input beat; returns 1 unless the block ignores it.
        function bit track_beat(input logic act, input logic [CW-1:0] cx,
                                input logic [CW-1:0] cy, input logic [RW-1:0] ra,
                                input logic [RW-1:0] rb, input logic [KW-1:0] col);
            t_pixel_beat pb;
            longint sx;
            longint sy;
            bit fin;
            if (act == mer_pkg::ACT_START) begin
                starts++;
                if (drawing)
                    restarts++;
                ctr_x = cx;
                ctr_y = cy;
                ink = col;
                a_sq = longint'(ra) * longint'(ra);
                b_sq = longint'(rb) * longint'(rb);
                off_x = 0;
                off_y = longint'(rb);
                dec = 4 * b_sq - 4 * a_sq * longint'(rb) + a_sq;
                region_two = 0;
                drawing = 1;
                test_switch();
                return 1;
            end
            if (!drawing)
                return 0;
            steps++;
            fin = (off_y == 0);
            for (int k = 0; k < 4; k++) begin
                if (k == 0 || k == 1)
                    sx = longint'(ctr_x) + off_x;
                else
                    sx = longint'(ctr_x) - off_x;
                if (k == 0 || k == 3)
                    sy = longint'(ctr_y) + off_y;
                else
                    sy = longint'(ctr_y) - off_y;
                pb.px = sx[PW-1:0];
                pb.py = sy[PW-1:0];
                pb.color = ink;
                case (k)
                    0: pb.quad = mer_pkg::QUAD_PP;
                    1: pb.quad = mer_pkg::QUAD_PN;
                    2: pb.quad = mer_pkg::QUAD_NN;
                    default: pb.quad = mer_pkg::QUAD_NP;
                endcase
                pb.last = (k == 3);
                pb.fin = fin;
                pending_pixels.push_back(pb);
            end
            if (fin) begin
                drawing = 0;
                ellipses_done++;
            end else begin
                next_point();
            end
            return 1;
        endfunction

        task check_pixel(input t_pixel_beat got);
            t_pixel_beat want;
            if (pending_pixels.size() == 0) begin
                report($sformatf("pixel (%0d,%0d) with nothing expected",
                                 $signed(got.px), $signed(got.py)));
            end else begin
                want = pending_pixels.pop_front();
                pixels_checked++;
                if (got.px !== want.px)
                    report($sformatf("pixel_x %0d, want %0d", $signed(got.px),
                                     $signed(want.px)));
                if (got.py !== want.py)
                    report($sformatf("pixel_y %0d, want %0d", $signed(got.py),
                                     $signed(want.py)));
                if (got.color !== want.color)
                    report($sformatf("pixel_color %h, want %h", got.color, want.color));
                if (got.quad !== want.quad)
                    report($sformatf("quadrant %0d, want %0d", got.quad, want.quad));
                if (got.last !== want.last)
                    report($sformatf("last_of_step %b, want %b", got.last, want.last));
                if (got.fin !== want.fin)
                    report($sformatf("final_point %b, want %b", got.fin, want.fin));
            end
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_action;
    logic [CW-1:0]         i_center_x;
    logic [CW-1:0]         i_center_y;
    logic [RW-1:0]         i_radius_a;
    logic [RW-1:0]         i_radius_b;
    logic [KW-1:0]         i_color_in;
    logic                  o_valid;
    logic                  i_ready;
    logic signed [PW-1:0]  o_pixel_x;
    logic signed [PW-1:0]  o_pixel_y;
    logic [KW-1:0]         o_pixel_color;
    logic [1:0]            o_quadrant;
    logic                  o_last_of_step;
    logic                  o_final_point;

    ellipse_scoreboard sb;
    int idle_cycles = 0;
    int items_sent = 0;
    int burst_left = 0;
    int rx_mode = 0;
    int rx_left = 0;
    int rx_phase = 0;

    midpoint_ellipse_raster u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_radius_a     (i_radius_a),
        .i_radius_b     (i_radius_b),
        .i_color_in     (i_color_in),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_color  (o_pixel_color),
        .o_quadrant     (o_quadrant),
        .o_last_of_step (o_last_of_step),
        .o_final_point  (o_final_point)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Sink: pick a stall pattern for a random stretch, always-ready among them.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(16, 80);
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 1) == 1);
            2: i_ready <= ((rx_phase % 7) >= 3);
            default: i_ready <= ($urandom_range(0, 5) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_pixel_beat got;
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (i_rst_n && o_valid && i_ready) begin
            got.px = o_pixel_x;
            got.py = o_pixel_y;
            got.color = o_pixel_color;
            got.quad = o_quadrant;
            got.last = o_last_of_step;
            got.fin = o_final_point;
            sb.check_pixel(got);
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    // Present one beat, hold it until accepted, then maybe open a gap.
    task automatic send_beat(input logic act, input logic [CW-1:0] cx,
                             input logic [CW-1:0] cy, input logic [RW-1:0] ra,
                             input logic [RW-1:0] rb, input logic [KW-1:0] col);
        int gap;
        i_valid <= 1'b1;
        i_action <= act;
        i_center_x <= cx;
        i_center_y <= cy;
        i_radius_a <= ra;
        i_radius_b <= rb;
        i_color_in <= col;
        do
            @(posedge i_clk);
        while (!o_ready);
        if (sb.track_beat(act, cx, cy, ra, rb, col))
            items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            if ($urandom_range(0, 4) == 0) begin
                gap = 0;
                burst_left = $urandom_range(20, 40);
            end else begin
                gap = $urandom_range(1, 7);
                burst_left = $urandom_range(1, 10);
            end
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic step_beat();
        send_beat(mer_pkg::ACT_STEP, CW'($urandom), CW'($urandom), RW'($urandom),
                  RW'($urandom), KW'($urandom));
    endtask

    task automatic start_beat(input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                              input logic [RW-1:0] ra, input logic [RW-1:0] rb,
                              input logic [KW-1:0] col);
        send_beat(mer_pkg::ACT_START, cx, cy, ra, rb, col);
    endtask

    // Step until the ellipse ends or the cap runs out.
    task automatic draw_steps(input int cap);
        int n;
        n = 0;
        while (sb.drawing && n < cap) begin
            step_beat();
            n++;
        end
    endtask

    // Hold off new beats until every queued pixel has come out.
    task automatic drain_pixels();
        i_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending_pixels.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int r;
        int ra;
        int rb;
        bit paused;
        sb = new();
        paused = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_action <= mer_pkg::ACT_START;
        i_center_x <= '0;
        i_center_y <= '0;
        i_radius_a <= '0;
        i_radius_b <= '0;
        i_color_in <= '0;
        i_ready <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle step, extremes, restart over a live ellipse, zero radii
        step_beat();
        start_beat('1, '1, '1, '1, '1);
        draw_steps(3);
        start_beat('0, '0, '1, RW'(1), '0);
        draw_steps(3);
        start_beat(12'd2048, 12'd1, '0, '0, 24'hA5A5A5);
        draw_steps(5);
        step_beat();
        start_beat(12'd100, 12'd4000, '0, 11'd3, 24'h00FF00);
        draw_steps(10);
        start_beat(12'd3, 12'd2, 11'd5, '0, 24'h123456);
        draw_steps(5);
        start_beat(CW'($urandom), CW'($urandom), 11'd3, 11'd2, KW'($urandom));
        draw_steps(20);
        start_beat('0, '0, 11'd1, '1, 24'h800001);
        draw_steps(2);
        drain_pixels();

        r = items_sent + RANDOM_ITEMS;
        while (items_sent < r) begin
            if (!paused && items_sent > r - RANDOM_ITEMS / 2) begin
                drain_pixels();
                paused = 1;
            end
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13: begin
                    if ($urandom_range(0, 4) == 0) begin
                        ra = $urandom_range(0, 20);
                        rb = $urandom_range(0, 20);
                    end else begin
                        ra = $urandom_range(0, 8);
                        rb = $urandom_range(0, 8);
                    end
                    start_beat(CW'($urandom), CW'($urandom), RW'(ra), RW'(rb),
                               KW'($urandom));
                    // sometimes cut the ellipse short so the next start drops it
                    if ($urandom_range(0, 9) == 0)
                        draw_steps($urandom_range(1, 4));
                    else
                        draw_steps(200);
                end
                14, 15, 16: begin
                    start_beat(CW'($urandom), CW'($urandom), RW'($urandom), RW'($urandom),
                               KW'($urandom));
                    draw_steps($urandom_range(1, 4));
                end
                default: begin
                    send_beat(1'($urandom), CW'($urandom), CW'($urandom), RW'($urandom),
                              RW'($urandom), KW'($urandom));
                end
            endcase
        end

        drain_pixels();
        repeat (40) @(posedge i_clk);
        if (sb.pending_pixels.size() != 0)
            sb.report($sformatf("%0d pixels never came out", sb.pending_pixels.size()));
        $display("run: %0d starts (%0d over a live ellipse), %0d steps, %0d ellipses ended",
                 sb.starts, sb.restarts, sb.steps, sb.ellipses_done);
        $display("run: %0d pixel beats compared, %0d mismatches", sb.pixels_checked,
                 sb.errors);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

@@ midpoint_ellipse_raster.f @@
rtl/core/mer_pkg.sv
rtl/core/mer_ctrl.sv
rtl/core/mer_dpath.sv
rtl/core/midpoint_ellipse_raster.sv
rtl/core/mer_checker.sv
tb/testbench.sv
